FILE: hdl/vfrm_pkg.sv
// Package for the ring-median void fill block: constants, types, helpers.
// No dependencies; every other file imports it.
package vfrm_pkg;

    localparam int RING_DEPTH = 24;
    localparam int MAX_RING   = 3;
    localparam int ALT_W      = 16;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int RING_W     = $clog2(MAX_RING + 1);

    typedef logic signed [ALT_W-1:0] t_alt;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [RING_W-1:0]       t_ring;
    typedef logic [1:0]              t_status;

    localparam t_alt ALT_LOW    = -16'sd435;
    localparam t_alt ALT_HIGH   = 16'sd8850;
    localparam t_alt VOID_RESET = -16'sd32768;

    localparam t_status ST_CENTER = 2'd0;
    localparam t_status ST_MEDIAN = 2'd1;
    localparam t_status ST_VOID   = 2'd2;

    localparam logic KIND_CENTER = 1'b0;
    localparam logic KIND_RING   = 1'b1;

    // store write port
    typedef struct packed {
        logic  en;
        t_addr addr;
        t_alt  data;
    } t_wr;

    // median select request / response
    typedef struct packed {
        logic start;
        t_cnt count;
    } t_sel_req;

    typedef struct packed {
        logic done;
        t_alt median;
    } t_sel_rsp;

    function automatic logic alt_valid(input t_alt a, input t_alt void_code);
        alt_valid = (a != void_code) && (a > ALT_LOW) && (a < ALT_HIGH);
    endfunction

endpackage

FILE: hdl/vfrm_if.sv
// Stream channel interfaces: sample beats in, result beats out.
// Depends on vfrm_pkg.
interface vfrm_in_if;
    import vfrm_pkg::*;
    logic valid;
    logic ready;
    logic kind;
    t_alt altitude;
    logic ring_end;
    modport source (output valid, output kind, output altitude, output ring_end, input ready);
    modport sink (input valid, input kind, input altitude, input ring_end, output ready);
endinterface

interface vfrm_out_if;
    import vfrm_pkg::*;
    logic    valid;
    logic    ready;
    t_alt    value;
    t_status status;
    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

FILE: hdl/void_fill_ring_median_core.sv
// Ring-median void fill, top level: query sequencing and output register.
// Depends on vfrm_pkg, vfrm_if (channels) and vfrm_store.
//
// Use: a query is a center beat (kind 0) on i_in, then, if the center is
// void, the beats of rings 1..3 (kind 1) with ring_end on each ring's last
// beat. A valid center leaves on o_out in the cycle after its beat with
// status 0. Valid ring samples are written into the store, one per cycle.
// At the end of the first ring with any valid sample the upper median
// (index count/2 in ascending order) is selected and sent with status 1;
// if ring 3 also ends empty the void code is sent with status 2.
// Rate: ring beats are taken one per cycle while i_in.ready is high. The
// median select scans the store once per candidate through its single
// read port; i_in.ready is low meanwhile.
// The result sits in an output register; while it waits on a stalled
// receiver i_in.ready is low and no beat is taken.
// Synchronous reset clears the sequencer and output valid and sets the
// void code to -32768; the store holds no reset value and needs no clear.
// i_cfg_wr_en writes the void code; write it only while idle.
module void_fill_ring_median_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vfrm_in_if.sink          i_in,
    vfrm_out_if.source       o_out,
    input  logic             i_cfg_wr_en,
    input  vfrm_pkg::t_alt   i_cfg_wr_data
);
    import vfrm_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_RINGS  = 2'd1;
    localparam logic [1:0] PH_SELECT = 2'd2;

    logic [1:0] r_phase, n_phase;
    t_ring      r_ring, n_ring;
    t_cnt       r_count, n_count;
    t_alt       r_void_code;

    logic    r_out_valid, n_out_valid;
    t_alt    r_out_value, n_out_value;
    t_status r_out_status, n_out_status;

    t_wr      wr;
    t_sel_req req;
    t_sel_rsp rsp;

    logic accept;
    logic in_ok;
    t_cnt cnt_inc;

    vfrm_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Every beat gives at most one result, so an empty or draining output
    // register is enough to take it.
    assign i_in.ready = (r_phase != PH_SELECT) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign in_ok      = alt_valid(i_in.altitude, r_void_code);

    always_comb begin
        n_phase      = r_phase;
        n_ring       = r_ring;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        wr.en        = 1'b0;
        wr.addr      = r_count[ADDR_W-1:0];
        wr.data      = i_in.altitude;
        req.start    = 1'b0;
        req.count    = r_count;
        cnt_inc      = r_count;

        if (accept && (i_in.kind == KIND_CENTER)) begin
            if (in_ok) begin
                n_phase      = PH_IDLE;
                n_out_valid  = 1'b1;
                n_out_value  = i_in.altitude;
                n_out_status = ST_CENTER;
            end else begin
                // new query; any repair in progress is dropped
                n_phase = PH_RINGS;
                n_ring  = t_ring'(1);
                n_count = '0;
            end
        end else if (accept && (r_phase == PH_RINGS)) begin
            // store full: further valid samples of this ring are dropped
            if (in_ok && (r_count < t_cnt'(RING_DEPTH))) begin
                wr.en   = 1'b1;
                cnt_inc = r_count + t_cnt'(1);
            end
            n_count = cnt_inc;
            if (i_in.ring_end) begin
                if (cnt_inc != '0) begin
                    req.start = 1'b1;
                    req.count = cnt_inc;
                    n_phase   = PH_SELECT;
                end else if (r_ring >= t_ring'(MAX_RING)) begin
                    n_phase      = PH_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_value  = r_void_code;
                    n_out_status = ST_VOID;
                end else begin
                    n_ring  = r_ring + t_ring'(1);
                    n_count = '0;
                end
            end
        end

        // output register is empty whenever the select engine is busy
        if (rsp.done) begin
            n_phase      = PH_IDLE;
            n_out_valid  = 1'b1;
            n_out_value  = rsp.median;
            n_out_status = ST_MEDIAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ring      <= t_ring'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_void_code <= VOID_RESET;
        end else begin
            r_phase     <= n_phase;
            r_ring      <= n_ring;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_void_code <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

endmodule

FILE: hdl/vfrm_store.sv
// Ring sample store with upper-median select engine.
// Depends on vfrm_pkg. One write port, one registered read port.
module vfrm_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vfrm_pkg::t_wr       i_wr,
    input  vfrm_pkg::t_sel_req  i_req,
    output vfrm_pkg::t_sel_rsp  o_rsp
);
    import vfrm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOADC = 2'd1;
    localparam logic [1:0] S_WAITC = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    t_alt r_mem [RING_DEPTH];
    t_alt r_rdata;

    logic [1:0] r_st, n_st;
    t_cnt r_n, n_n;
    t_cnt r_i, n_i;
    t_cnt r_k, n_k;
    t_cnt r_lt, n_lt;
    t_cnt r_le, n_le;
    t_alt r_cand, n_cand;
    t_alt r_med, n_med;
    logic r_done, n_done;

    logic  rd_en;
    t_addr rd_addr;
    t_cnt  k_next;
    t_cnt  lt_f;
    t_cnt  le_f;
    t_cnt  half;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign k_next = r_k + t_cnt'(1);
    assign half   = r_n >> 1;
    assign lt_f   = r_lt + t_cnt'(r_rdata < r_cand);
    assign le_f   = r_le + t_cnt'(r_rdata <= r_cand);

    always_comb begin
        n_st    = r_st;
        n_n     = r_n;
        n_i     = r_i;
        n_k     = r_k;
        n_lt    = r_lt;
        n_le    = r_le;
        n_cand  = r_cand;
        n_med   = r_med;
        n_done  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_i[ADDR_W-1:0];
        case (r_st)
            S_IDLE: begin
                if (i_req.start) begin
                    n_n  = i_req.count;
                    n_i  = '0;
                    n_st = S_LOADC;
                end
            end
            S_LOADC: begin
                rd_en   = 1'b1;
                rd_addr = r_i[ADDR_W-1:0];
                n_st    = S_WAITC;
            end
            S_WAITC: begin
                n_cand  = r_rdata;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_k     = '0;
                n_lt    = '0;
                n_le    = '0;
                n_st    = S_SCAN;
            end
            S_SCAN: begin
                // r_rdata holds entry r_k; prefetch the next one
                rd_en   = (k_next < r_n);
                rd_addr = k_next[ADDR_W-1:0];
                n_lt    = lt_f;
                n_le    = le_f;
                n_k     = k_next;
                if (k_next == r_n) begin
                    if ((lt_f <= half) && (half < le_f)) begin
                        n_med  = r_cand;
                        n_done = 1'b1;
                        n_st   = S_IDLE;
                    end else begin
                        n_i  = r_i + t_cnt'(1);
                        n_st = S_LOADC;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_i    <= n_i;
        r_k    <= n_k;
        r_lt   <= n_lt;
        r_le   <= n_le;
        r_cand <= n_cand;
        r_med  <= n_med;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.median = r_med;

endmodule

FILE: hdl/vfrm_checker.sv
// Port-level checks for void_fill_ring_median_core, attached by bind.
// Depends on vfrm_pkg.
module vfrm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input vfrm_pkg::t_alt    i_out_value,
    input vfrm_pkg::t_status i_out_status
);
    import vfrm_pkg::*;

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_value) && $stable(i_out_status)))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_CENTER || i_out_status == ST_MEDIAN ||
                         i_out_status == ST_VOID))
        else $error("bad status code");

    // passed and repaired values are always in the valid altitude range
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != ST_VOID)) |->
        ((i_out_value > ALT_LOW) && (i_out_value < ALT_HIGH)))
        else $error("repaired value out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind void_fill_ring_median_core vfrm_checker u_vfrm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value),
    .i_out_status (o_out.status)
);

FILE: tb/sv/tb_void_fill_ring_median_core.sv
// Self-checking testbench for void_fill_ring_median_core: random query streams
// with bursty sender, stalling receiver and void-code changes between phases.
// Depends on vfrm_pkg, vfrm_if and the core RTL.
`timescale 1ns / 100ps

module tb_void_fill_ring_median_core;
    import vfrm_pkg::*;

    // random beats per void-code phase; six phases give roughly 1850 beats
    localparam int PHASE_BEATS   = 308;
    // a short pause after each drain covers any tail work
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    // the limit covers the worst median select plus stalls and gaps, with wide margin
    localparam int STALL_LIMIT   = 4000;
    localparam int SHOWN_MAX     = 10;

    typedef struct packed {
        logic kind;
        t_alt altitude;
        logic ring_end;
        logic hold;       // sender waits for all due results before this beat
    } t_sample_beat;

    typedef struct packed {
        t_alt    value;
        t_status status;
    } t_fill;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    t_alt cfg_wr_data;

    vfrm_in_if  tb_in ();
    vfrm_out_if tb_out ();

    void_fill_ring_median_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (tb_in),
        .o_out         (tb_out),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    t_sample_beat samples_to_send[$];
    t_fill        fills_due[$];
    t_sample_beat on_wire;
    t_fill        oldest_fill;
    int           queued_total = 0;
    int           accepted_total = 0;
    int           bad_beats = 0;
    int           idle_cycles = 0;

    // sender burst / gap shaping and receiver stall pattern
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_left = 0;
    logic rx_on = 1'b1;

    // predictor state: its own copy of the void code and the ring store
    t_alt void_now;
    t_alt ring_vals[RING_DEPTH];
    int   ring_cnt;
    int   ring_idx;
    bit   repairing;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic bit usable(input t_alt a, input t_alt vc);
        return (a != vc) && (a > ALT_LOW) && (a < ALT_HIGH);
    endfunction

    // upper median: element count/2 of the stored samples in ascending order
    function automatic t_alt ring_upper_median();
        t_alt sorted[RING_DEPTH];
        t_alt x;
        int   j;
        for (int i = 0; i < ring_cnt; i++) begin
            x = ring_vals[i];
            j = i;
            while (j > 0 && sorted[j-1] > x) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
        end
        return sorted[ring_cnt / 2];
    endfunction

    // Advance the predicted query state by one accepted beat and queue the
    // repaired (or passed, or void) altitude that it yields, if any.
    task automatic predict_fill(input t_sample_beat b);
        t_fill r;
        bit    got;
        got = 1'b0;
        if (b.kind == KIND_CENTER) begin
            // a center always starts over, even in the middle of a repair
            if (usable(b.altitude, void_now)) begin
                repairing = 1'b0;
                r.value   = b.altitude;
                r.status  = ST_CENTER;
                got       = 1'b1;
            end else begin
                repairing = 1'b1;
                ring_idx  = 1;
                ring_cnt  = 0;
            end
        end else if (repairing) begin
            // store full: extra valid samples of the ring are dropped
            if (usable(b.altitude, void_now) && ring_cnt < RING_DEPTH) begin
                ring_vals[ring_cnt] = b.altitude;
                ring_cnt++;
            end
            if (b.ring_end) begin
                if (ring_cnt > 0) begin
                    repairing = 1'b0;
                    r.value   = ring_upper_median();
                    r.status  = ST_MEDIAN;
                    got       = 1'b1;
                end else if (ring_idx >= MAX_RING) begin
                    repairing = 1'b0;
                    r.value   = void_now;
                    r.status  = ST_VOID;
                    got       = 1'b1;
                end else begin
                    // empty ring, not the last: move out one ring
                    ring_idx++;
                    ring_cnt = 0;
                end
            end
        end
        // ring beats while idle fall through with nothing due
        if (got)
            fills_due = {fills_due, r};
    endtask

    function automatic t_alt pick_good(input t_alt vc);
        t_alt a;
        do begin
            case ($urandom_range(0, 5))
                0:       a = t_alt'(ALT_LOW + 1);
                1:       a = t_alt'(ALT_HIGH - 1);
                2:       a = t_alt'(int'($urandom_range(0, 15)));  // duplicates
                default: a = t_alt'(int'($urandom_range(0, 9283)) - 434);
            endcase
        end while (a == vc);
        return a;
    endfunction

    function automatic t_alt pick_bad(input t_alt vc);
        t_alt a;
        do begin
            case ($urandom_range(0, 5))
                0:       a = vc;
                1:       a = ALT_LOW;
                2:       a = ALT_HIGH;
                3:       a = t_alt'(int'($urandom_range(0, 32333)) - 32768);
                4:       a = t_alt'(int'($urandom_range(8850, 32767)));
                default: a = t_alt'($urandom);
            endcase
        end while (usable(a, vc));
        return a;
    endfunction

    task automatic add_beat(input logic kind, input t_alt alt, input logic re,
                            input logic hold);
        t_sample_beat b;
        b.kind     = kind;
        b.altitude = alt;
        b.ring_end = re;
        b.hold     = hold;
        samples_to_send = {samples_to_send, b};
        queued_total++;
    endtask

    task automatic note_bad(input string what, input t_fill got);
        bad_beats++;
        if (bad_beats <= SHOWN_MAX)
            $display("%0t: %s, got value %0d status %0d", $time, what,
                     $signed(got.value), got.status);
    endtask

    // One void-code phase: optional register write while idle, then random
    // queries, then drain. Each phase closes on a valid center so the block
    // is back to idle before the next write.
    task automatic run_phase(input bit do_write, input t_alt code);
        int   counted;
        int   q;
        int   roll;
        int   hit;
        int   len;
        int   good_pct;
        int   forced;
        int   stop_at;
        int   beats;
        bit   cut;
        bit   hold_it;
        t_alt a;
        if (do_write) begin
            @(posedge i_clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= code;
            @(posedge i_clk);
            cfg_wr_en   <= 1'b0;
            void_now = code;
        end
        counted = 0;
        q = 0;
        while (counted < PHASE_BEATS) begin
            // stray ring beat: ignored unless the previous query was cut short
            if ($urandom_range(0, 19) == 0)
                add_beat(KIND_RING, t_alt'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            hold_it = (q == 0) || ($urandom_range(0, 39) == 0);
            q++;
            counted++;
            if ($urandom_range(0, 4) == 0) begin
                add_beat(KIND_CENTER, pick_good(void_now), 1'($urandom_range(0, 1)),
                         hold_it);
                continue;
            end
            add_beat(KIND_CENTER, pick_bad(void_now), 1'($urandom_range(0, 1)), hold_it);
            // ring that first holds a valid sample; past MAX_RING means none does
            roll = $urandom_range(0, 99);
            hit  = (roll < 45) ? 1 : (roll < 65) ? 2 : (roll < 80) ? 3 : MAX_RING + 1;
            // now and then a query is abandoned mid-ring by the next center
            stop_at = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 12)) : -1;
            beats = 0;
            cut   = 1'b0;
            for (int ring = 1; ring <= MAX_RING && ring <= hit && !cut; ring++) begin
                // long rings can push past the 24-entry store
                len = ($urandom_range(0, 6) == 0) ? int'($urandom_range(20, 30))
                                                  : int'($urandom_range(1, 8));
                case ($urandom_range(0, 2))
                    0:       good_pct = 25;
                    1:       good_pct = 50;
                    default: good_pct = 100;
                endcase
                forced = $urandom_range(0, len - 1);
                for (int k = 0; k < len; k++) begin
                    if (beats == stop_at) begin
                        cut = 1'b1;
                        break;
                    end
                    if (ring == hit && (k == forced || $urandom_range(1, 100) <= good_pct))
                        a = pick_good(void_now);
                    else
                        a = pick_bad(void_now);
                    add_beat(KIND_RING, a, (k == len - 1), 1'b0);
                    beats++;
                    counted++;
                end
            end
            // ring beat after the result went out: ignored
            if (!cut && $urandom_range(0, 19) == 0)
                add_beat(KIND_RING, pick_good(void_now), 1'b1, 1'b0);
        end
        add_beat(KIND_CENTER, pick_good(void_now), 1'b0, 1'b0);
        // drain: every beat taken and every result back
        do @(posedge i_clk);
        while (accepted_total != queued_total || fills_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sender: pops pending beats in bursts, holds payload while not ready.
    // Prediction runs on the beat accepted at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tb_in.valid <= 1'b0;
        end else begin
            if (tb_in.valid && tb_in.ready) begin
                predict_fill(on_wire);
                accepted_total++;
            end
            if (!tb_in.valid || tb_in.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tb_in.valid <= 1'b0;
                end else if (samples_to_send.size() != 0 &&
                             !(samples_to_send[0].hold && fills_due.size() != 0)) begin
                    on_wire = samples_to_send.pop_front();
                    tb_in.valid    <= 1'b1;
                    tb_in.kind     <= on_wire.kind;
                    tb_in.altitude <= on_wire.altitude;
                    tb_in.ring_end <= on_wire.ring_end;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // mostly short bursts, sometimes a long gap-free stretch
                        burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 200))
                                                                 : int'($urandom_range(1, 40));
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0
                                                                 : int'($urandom_range(1, 10));
                    end
                end else begin
                    tb_in.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready runs high or low for random stretches, with the
    // occasional long stall-free run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    rx_on   = 1'b1;
                    rx_left = $urandom_range(100, 300);
                end
                1, 2, 3, 4, 5: begin
                    rx_on   = 1'b1;
                    rx_left = $urandom_range(1, 20);
                end
                default: begin
                    rx_on   = 1'b0;
                    rx_left = $urandom_range(1, 12);
                end
            endcase
        end else begin
            rx_left--;
        end
        tb_out.ready <= rx_on;
    end

    // ------------------------------------------------------------------
    // Monitor: each result beat against the oldest due fill
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && tb_out.valid && tb_out.ready) begin
            if (fills_due.size() == 0) begin
                note_bad("result beat with nothing due", fills_due.size() == 0 ?
                         t_fill'({tb_out.value, tb_out.status}) : oldest_fill);
            end else begin
                oldest_fill = fills_due.pop_front();
                if (oldest_fill.value !== tb_out.value ||
                    oldest_fill.status !== tb_out.status)
                    note_bad($sformatf("mismatch, expected value %0d status %0d",
                                       $signed(oldest_fill.value), oldest_fill.status),
                             t_fill'({tb_out.value, tb_out.status}));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((tb_in.valid && tb_in.ready) || (tb_out.valid && tb_out.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("void_fill_ring_median_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        tb_in.valid     = 1'b0;
        tb_in.kind      = KIND_CENTER;
        tb_in.altitude  = '0;
        tb_in.ring_end  = 1'b0;
        tb_out.ready    = 1'b0;
        void_now        = VOID_RESET;
        repairing       = 1'b0;
        ring_idx        = 1;
        ring_cnt        = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset void code.
        // Valid centers, including both range edges; ring_end ignored on a center.
        add_beat(KIND_CENTER, 16'sd0, 1'b0, 1'b0);
        add_beat(KIND_CENTER, -16'sd434, 1'b1, 1'b0);
        add_beat(KIND_CENTER, 16'sd8849, 1'b0, 1'b0);
        // Low edge is invalid: ring 1 holds only out-of-range and void
        // samples, ring 2 gives the upper median of four.
        add_beat(KIND_CENTER, -16'sd435, 1'b0, 1'b0);
        add_beat(KIND_RING, 16'sd8850, 1'b0, 1'b0);
        add_beat(KIND_RING, -16'sd32768, 1'b0, 1'b0);
        add_beat(KIND_RING, 16'sd32767, 1'b1, 1'b0);
        add_beat(KIND_RING, 16'sd5, 1'b0, 1'b0);
        add_beat(KIND_RING, -16'sd434, 1'b0, 1'b0);
        add_beat(KIND_RING, 16'sd8849, 1'b0, 1'b0);
        add_beat(KIND_RING, 16'sd7, 1'b1, 1'b0);
        // ring beat while idle
        add_beat(KIND_RING, 16'sd50, 1'b1, 1'b0);
        // all three rings empty: void code out; wait for all results first
        add_beat(KIND_CENTER, 16'sd8850, 1'b0, 1'b1);
        add_beat(KIND_RING, -16'sd32768, 1'b1, 1'b0);
        add_beat(KIND_RING, -16'sd500, 1'b1, 1'b0);
        add_beat(KIND_RING, 16'sd9000, 1'b1, 1'b0);
        // repair abandoned by a new, valid center
        add_beat(KIND_CENTER, -16'sd32768, 1'b0, 1'b0);
        add_beat(KIND_RING, 16'sd10, 1'b0, 1'b0);
        add_beat(KIND_CENTER, 16'sd20, 1'b0, 1'b0);

        run_phase(1'b0, VOID_RESET);
        run_phase(1'b1, 16'sd32767);
        run_phase(1'b1, -16'sd434);        // void code inside the valid range
        run_phase(1'b1, 16'sd0);
        run_phase(1'b1, -16'sd32768);
        run_phase(1'b1, t_alt'($urandom));

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_beats == 0 && fills_due.size() == 0)
            $display("void_fill_ring_median_core test passed");
        else
            $display("void_fill_ring_median_core test failed");
        $finish;
    end

endmodule
